// ----- rtl/sgwd_pkg.sv -----
// Package: shared constants and types for the swipe gesture wake detector.
package sgwd_pkg;

    localparam int COORD_BITS_DEF = 12;

    // Byte address width of the register port: six 32-bit registers.
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;
    localparam int REG_IDX_W = 3;

    // Percentages: wake/sleep distance and height of the bottom band.
    localparam int PCT_NEED = 60;
    localparam int PCT_BAND = 13;
    localparam int PCT_FULL = 100;

    typedef enum logic [2:0] {
        OP_POSITION   = 3'd0,
        OP_RELEASE    = 3'd1,
        OP_REJECT     = 3'd2,
        OP_DISPLAY    = 3'd3,
        OP_DISCONNECT = 3'd4
    } opcode_t;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_ENABLE     = 3'd0,
        REG_SLEEP_ONLY = 3'd1,
        REG_X_LO       = 3'd2,
        REG_X_HI       = 3'd3,
        REG_Y_LO       = 3'd4,
        REG_Y_HI       = 3'd5
    } reg_idx_t;

endpackage

// ----- rtl/swipe_gesture_wake_detector_core.sv -----
// Top level: swipe gesture wake/sleep detector with register port.
//
//  channel  | handshake               | payload
//  ---------+-------------------------+-----------------------------------
//  input    | in_valid / in_ready     | opcode, pos_x, pos_y, screen_off
//  output   | out_valid / out_ready   | power_key
//  config   | psel/penable/pwrite     | paddr, pwdata, prdata (pready high)
//
// One request is taken per cycle while the output is not stalled. A request is
// held in the input register after its acceptance, evaluated against the gesture
// state there, and its result is registered in the output register when the input
// register advances.
// rst_n resets the gesture state and the registers and clears both pipeline valids at
// once. A stalled output holds the input register; the input side stalls
// only while both registers are full and out_ready is low.
module swipe_gesture_wake_detector_core
    import sgwd_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // register port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [ADDR_W-1:0]     paddr,
    input  logic [DATA_W-1:0]     pwdata,
    output logic [DATA_W-1:0]     prdata,
    output logic                  pready,
    // touch event requests
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [2:0]            opcode,
    input  logic [COORD_BITS-1:0] pos_x,
    input  logic [COORD_BITS-1:0] pos_y,
    input  logic                  screen_off,
    // power key results
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  power_key
);

    // Scaled products: (best+1)*100 and window span * 60 fit in CB+7 bits.
    localparam int SCALE_W = COORD_BITS + 7;

    // Configuration registers
    logic                  enable_reg;
    logic                  sleep_only_reg;
    logic [COORD_BITS-1:0] x_lo_reg;
    logic [COORD_BITS-1:0] x_hi_reg;
    logic [COORD_BITS-1:0] y_lo_reg;
    logic [COORD_BITS-1:0] y_hi_reg;

    // Window spans scaled by their percentages, refreshed every cycle
    logic [SCALE_W-1:0]    need_scaled_reg;
    logic [SCALE_W-1:0]    band_scaled_reg;

    // Input register
    logic                  s1_valid_reg;
    opcode_t               s1_opcode_reg;
    logic [COORD_BITS-1:0] s1_pos_x_reg;
    logic [COORD_BITS-1:0] s1_pos_y_reg;
    logic                  s1_screen_off_reg;

    // Output register
    logic                  out_valid_reg;
    logic                  power_key_reg;

    // Gesture state
    logic                  suspended_reg,     suspended_next;
    logic                  contact_reg,       contact_next;
    logic                  start_valid_reg,   start_valid_next;
    logic                  blocked_reg,       blocked_next;
    logic                  armed_reg,         armed_next;
    logic [COORD_BITS-1:0] start_x_reg,       start_x_next;
    logic [COORD_BITS-1:0] best_progress_reg, best_progress_next;
    logic                  fire_next;

    logic                  s1_advance;
    logic                  cfg_write;
    reg_idx_t              cfg_idx;

    logic                  inside_win;
    logic [COORD_BITS-1:0] start_x_eff;
    logic [COORD_BITS:0]   disp;
    logic [COORD_BITS-1:0] best_upd;
    logic [SCALE_W-1:0]    prog_scaled;
    logic [SCALE_W-1:0]    y_room_scaled;
    logic [COORD_BITS-1:0] y_room;
    logic                  reach;
    logic                  above_band;
    logic                  mode_wake;
    logic                  mode_sleep;

    // ------------------------------------------------------------------
    // Register port: writes land at the access phase, reads are plain mux
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_idx   = reg_idx_t'(paddr[ADDR_W-1:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg     <= 1'b1;
            sleep_only_reg <= 1'b0;
            x_lo_reg       <= '0;
            x_hi_reg       <= '1;
            y_lo_reg       <= '0;
            y_hi_reg       <= '1;
        end
        else if (cfg_write)
        begin
            case (cfg_idx)
                REG_ENABLE:     enable_reg     <= pwdata[0];
                REG_SLEEP_ONLY: sleep_only_reg <= pwdata[0];
                REG_X_LO:       x_lo_reg       <= pwdata[COORD_BITS-1:0];
                REG_X_HI:       x_hi_reg       <= pwdata[COORD_BITS-1:0];
                REG_Y_LO:       y_lo_reg       <= pwdata[COORD_BITS-1:0];
                REG_Y_HI:       y_hi_reg       <= pwdata[COORD_BITS-1:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_ENABLE:     prdata = DATA_W'(enable_reg);
            REG_SLEEP_ONLY: prdata = DATA_W'(sleep_only_reg);
            REG_X_LO:       prdata = DATA_W'(x_lo_reg);
            REG_X_HI:       prdata = DATA_W'(x_hi_reg);
            REG_Y_LO:       prdata = DATA_W'(y_lo_reg);
            REG_Y_HI:       prdata = DATA_W'(y_hi_reg);
            default:        prdata = '0;
        endcase
    end

    // Registers change only while idle: a rule for the user, the block does not enforce it.
    // The scaled spans are registered, so only then are they settled before evaluation.
    // An inverted window wraps here, but then no position is inside anyway.
    always_ff @(posedge clk)
    begin
        need_scaled_reg <= SCALE_W'(x_hi_reg - x_lo_reg) * SCALE_W'(PCT_NEED);
        band_scaled_reg <= SCALE_W'(y_hi_reg - y_lo_reg) * SCALE_W'(PCT_BAND);
    end

    // ------------------------------------------------------------------
    // Pipeline handshake: input register feeds the output register
    // ------------------------------------------------------------------
    assign s1_advance = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready   = !s1_valid_reg || s1_advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_opcode_reg     <= opcode_t'(opcode);
            s1_pos_x_reg      <= pos_x;
            s1_pos_y_reg      <= pos_y;
            s1_screen_off_reg <= screen_off;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance)
        begin
            power_key_reg <= fire_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign power_key = power_key_reg;

    // ------------------------------------------------------------------
    // Position evaluation
    // ------------------------------------------------------------------
    assign inside_win = (s1_pos_x_reg >= x_lo_reg) && (s1_pos_x_reg <= x_hi_reg) &&
                        (s1_pos_y_reg >= y_lo_reg) && (s1_pos_y_reg <= y_hi_reg);

    // The first position of a gesture becomes its start point
    assign start_x_eff = start_valid_reg ? start_x_reg : s1_pos_x_reg;

    // Rightward while suspended, leftward while awake; sign bit on top
    assign disp = suspended_reg ?
                  ({1'b0, s1_pos_x_reg} - {1'b0, start_x_eff}) :
                  ({1'b0, start_x_eff} - {1'b0, s1_pos_x_reg});

    assign best_upd = (!disp[COORD_BITS] && (disp[COORD_BITS-1:0] > best_progress_reg)) ?
                      disp[COORD_BITS-1:0] : best_progress_reg;

    // best >= floor(span*60/100)  <=>  (best+1)*100 > span*60
    assign prog_scaled = (SCALE_W'(best_upd) + SCALE_W'(1)) * SCALE_W'(PCT_FULL);
    assign reach       = prog_scaled > need_scaled_reg;

    // y inside the bottom band: y > y_hi - floor(span*13/100)
    // <=> (y_hi - y + 1)*100 <= span*13; valid only with y inside the window
    assign y_room        = y_hi_reg - s1_pos_y_reg;
    assign y_room_scaled = (SCALE_W'(y_room) + SCALE_W'(1)) * SCALE_W'(PCT_FULL);
    assign above_band    = y_room_scaled <= band_scaled_reg;

    assign mode_wake  = suspended_reg && enable_reg && !sleep_only_reg;
    assign mode_sleep = !suspended_reg && enable_reg;

    // ------------------------------------------------------------------
    // Gesture state update, one request per advance
    // ------------------------------------------------------------------
    always_comb
    begin
        suspended_next     = suspended_reg;
        contact_next       = contact_reg;
        start_valid_next   = start_valid_reg;
        blocked_next       = blocked_reg;
        armed_next         = armed_reg;
        start_x_next       = start_x_reg;
        best_progress_next = best_progress_reg;
        fire_next          = 1'b0;

        if (s1_advance)
        begin
            case (s1_opcode_reg)
                OP_POSITION:
                begin
                    contact_next = 1'b1;
                    if (!blocked_reg)
                    begin
                        if (inside_win && (mode_wake || (mode_sleep && above_band)))
                        begin
                            start_x_next       = start_x_eff;
                            start_valid_next   = 1'b1;
                            best_progress_next = best_upd;
                            if (reach && armed_reg)
                            begin
                                armed_next = 1'b0;
                                fire_next  = 1'b1;
                            end
                        end
                        else
                        begin
                            // invalidate with the finger down: block until lift
                            blocked_next       = 1'b1;
                            armed_next         = 1'b1;
                            start_valid_next   = 1'b0;
                            best_progress_next = '0;
                            if (inside_win)
                            begin
                                start_x_next = start_x_eff;
                            end
                        end
                    end
                end
                OP_RELEASE:
                begin
                    armed_next         = 1'b1;
                    start_valid_next   = 1'b0;
                    best_progress_next = '0;
                    blocked_next       = 1'b0;
                    contact_next       = 1'b0;
                end
                OP_REJECT:
                begin
                    contact_next       = 1'b1;
                    blocked_next       = 1'b1;
                    armed_next         = 1'b1;
                    start_valid_next   = 1'b0;
                    best_progress_next = '0;
                end
                OP_DISPLAY:
                begin
                    suspended_next     = s1_screen_off_reg;
                    blocked_next       = contact_reg;
                    armed_next         = 1'b1;
                    start_valid_next   = 1'b0;
                    best_progress_next = '0;
                end
                OP_DISCONNECT:
                begin
                    armed_next         = 1'b1;
                    start_valid_next   = 1'b0;
                    best_progress_next = '0;
                    blocked_next       = 1'b0;
                    contact_next       = 1'b0;
                end
                default:
                begin
                    // unused codes: drop without touching state
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            suspended_reg     <= 1'b0;
            contact_reg       <= 1'b0;
            start_valid_reg   <= 1'b0;
            blocked_reg       <= 1'b0;
            armed_reg         <= 1'b1;
            start_x_reg       <= '0;
            best_progress_reg <= '0;
        end
        else
        begin
            suspended_reg     <= suspended_next;
            contact_reg       <= contact_next;
            start_valid_reg   <= start_valid_next;
            blocked_reg       <= blocked_next;
            armed_reg         <= armed_next;
            start_x_reg       <= start_x_next;
            best_progress_reg <= best_progress_next;
        end
    end

endmodule

// ----- rtl/sgwd_checker.sv -----
// Checker: port-level assertions for the detector, bound to the top level.
module sgwd_checker
    import sgwd_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_valid,
    input logic                  in_ready,
    input logic [2:0]            opcode,
    input logic [COORD_BITS-1:0] pos_x,
    input logic [COORD_BITS-1:0] pos_y,
    input logic                  screen_off,
    input logic                  out_valid,
    input logic                  out_ready,
    input logic                  power_key
);

    // A waiting request holds its payload until taken
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_ready) |=>
            (in_valid && $stable(opcode) && $stable(pos_x) && $stable(pos_y) &&
             $stable(screen_off)))
        else $error("request dropped or changed while stalled");

    // A waiting result holds until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(power_key)))
        else $error("result dropped or changed while stalled");

    // An empty output slot never back-pressures the input
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with an empty output");

    // A fresh result follows a matching request taken before it
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready, 2))
        else $error("result without a matching request");

    // Reset empties the output
    a_reset_clear: assert property (@(posedge clk)
        !rst_n |=> !out_valid)
        else $error("result visible during reset");

endmodule

bind swipe_gesture_wake_detector_core sgwd_checker #(
    .COORD_BITS(COORD_BITS)
) u_sgwd_checker (.*);

// ----- test/tb.sv -----
// Testbench for the swipe gesture wake detector: random touch traffic checked against a predictor.
`timescale 1ns / 100ps

module tb;
    import sgwd_pkg::*;

    typedef logic [COORD_BITS_DEF-1:0] coord_t;

    // One touch event request as it is offered to the detector.
    typedef struct packed {
        logic [2:0] op;
        coord_t     x;
        coord_t     y;
        logic       off;
    } touch_req_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    logic              in_valid = 1'b0;
    logic              in_ready;
    logic [2:0]        opcode = '0;
    coord_t            pos_x = '0;
    coord_t            pos_y = '0;
    logic              screen_off = 1'b0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic              power_key;

    swipe_gesture_wake_detector_core dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .opcode     (opcode),
        .pos_x      (pos_x),
        .pos_y      (pos_y),
        .screen_off (screen_off),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .power_key  (power_key)
    );

    always #4 clk = ~clk;

    // Detector settings as the predictor sees them (reset values to start with).
    logic   cfg_enable = 1'b1;
    logic   cfg_sleep_only = 1'b0;
    coord_t cfg_x_lo = '0;
    coord_t cfg_x_hi = '1;
    coord_t cfg_y_lo = '0;
    coord_t cfg_y_hi = '1;

    // Gesture tracking state of the predictor.
    logic   trk_suspended = 1'b0;
    logic   trk_contact = 1'b0;
    logic   trk_start_valid = 1'b0;
    logic   trk_blocked = 1'b0;
    logic   trk_armed = 1'b1;
    coord_t trk_start_x = '0;
    coord_t trk_best = '0;

    touch_req_t touch_q[$];      // requests waiting to be offered
    bit         expected_keys[$]; // power key values still owed by the detector
    int         mismatches = 0;
    int         keys_seen = 0;
    bit         gen_asleep = 1'b0; // screen state as the stimulus generator last set it

    // Start a fresh gesture: re-arm the one-shot and forget the start point.
    function automatic void restart_gesture();
        trk_armed = 1'b1;
        trk_start_valid = 1'b0;
        trk_best = '0;
    endfunction

    // Invalidate the gesture; it stays blocked while the finger is still down.
    function automatic void drop_gesture();
        trk_blocked = trk_contact;
        restart_gesture();
    endfunction

    // Advance the gesture state by one event and return the power key it causes.
    function automatic bit predict_power_key(logic [2:0] op, coord_t px, coord_t py, logic off);
        bit fire;
        int disp;
        int need;
        int y_line;
        fire = 1'b0;
        case (op)
            OP_POSITION: begin
                trk_contact = 1'b1;
                if (!trk_blocked) begin
                    if (px < cfg_x_lo || px > cfg_x_hi || py < cfg_y_lo || py > cfg_y_hi) begin
                        drop_gesture();
                    end
                    else begin
                        if (!trk_start_valid) begin
                            trk_start_x = px;
                            trk_start_valid = 1'b1;
                        end
                        // wake swipes go rightward, sleep swipes leftward
                        disp = trk_suspended ? int'(px) - int'(trk_start_x)
                                             : int'(trk_start_x) - int'(px);
                        if (disp > int'(trk_best))
                            trk_best = coord_t'(disp);
                        need = (int'(cfg_x_hi) - int'(cfg_x_lo)) * PCT_NEED / PCT_FULL;
                        y_line = int'(cfg_y_hi)
                               - (int'(cfg_y_hi) - int'(cfg_y_lo)) * PCT_BAND / PCT_FULL;
                        if (trk_suspended ? !(cfg_enable && !cfg_sleep_only)
                                          : (!cfg_enable || int'(py) <= y_line)) begin
                            drop_gesture();
                        end
                        else if (int'(trk_best) >= need && trk_armed) begin
                            trk_armed = 1'b0;
                            fire = 1'b1;
                        end
                    end
                end
            end
            OP_RELEASE: begin
                restart_gesture();
                trk_blocked = 1'b0;
                trk_contact = 1'b0;
            end
            OP_REJECT: begin
                trk_contact = 1'b1;
                drop_gesture();
            end
            OP_DISPLAY: begin
                trk_suspended = off;
                drop_gesture();
            end
            OP_DISCONNECT: begin
                drop_gesture();
                trk_blocked = 1'b0;
                trk_contact = 1'b0;
            end
            default: ; // unused codes leave everything alone
        endcase
        return fire;
    endfunction

    // ------------------------------------------------------------------
    // Driver: offer queued requests in bursts, hold each until accepted.
    // ------------------------------------------------------------------
    touch_req_t nxt;
    int         burst_left = 0;
    int         gap_left = 0;

    always @(posedge clk) begin
        if (rst_n) begin
            // Predict at acceptance, using the payload the detector has just taken.
            if (in_valid && in_ready)
                expected_keys.push_back(predict_power_key(opcode, pos_x, pos_y, screen_off));
            if (!in_valid || in_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (touch_q.size() > 0) begin
                    nxt = touch_q.pop_front();
                    opcode <= nxt.op;
                    pos_x <= nxt.x;
                    pos_y <= nxt.y;
                    screen_off <= nxt.off;
                    in_valid <= 1'b1;
                    if (burst_left > 0) begin
                        burst_left--;
                    end
                    else begin
                        // Mix short bursts with the odd long unbroken stretch.
                        if ($urandom_range(0, 5) == 0) begin
                            burst_left = $urandom_range(40, 80);
                            gap_left = 0;
                        end
                        else begin
                            burst_left = $urandom_range(0, 20);
                            gap_left = $urandom_range(0, 1) ? 0 : $urandom_range(1, 8);
                        end
                    end
                end
                else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: check each power key result and drive the receiver stalls.
    // ------------------------------------------------------------------
    int hold_left = 0;
    bit long_hold_done = 1'b0;
    int ready_mode = 0;
    int mode_left = 0;
    bit want;

    always @(posedge clk) begin
        if (rst_n) begin
            if (out_valid && out_ready) begin
                keys_seen++;
                if (expected_keys.size() == 0) begin
                    $display("%0t: unexpected power key result, expected none, got %0b",
                             $time, power_key);
                    mismatches++;
                end
                else begin
                    want = expected_keys.pop_front();
                    if (power_key !== want) begin
                        $display("%0t: power_key mismatch, expected %0b, got %0b",
                                 $time, want, power_key);
                        mismatches++;
                    end
                end
            end
            // Hold off once for a long stretch so that the detector fills and
            // stalls its input while the driver keeps offering requests.
            if (hold_left > 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (!long_hold_done && keys_seen >= 300) begin
                long_hold_done = 1'b1;
                hold_left = 400;
                out_ready <= 1'b0;
            end
            else begin
                if (mode_left == 0) begin
                    ready_mode = $urandom_range(0, 3);
                    mode_left = $urandom_range(16, 96);
                end
                else begin
                    mode_left--;
                end
                case (ready_mode)
                    0:       out_ready <= 1'b1;
                    1:       out_ready <= 1'($urandom_range(0, 1));
                    2:       out_ready <= ($urandom_range(0, 3) == 0);
                    default: out_ready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic push_req(logic [2:0] op, int x, int y, logic off);
        touch_req_t r;
        r.op = op;
        r.x = coord_t'(x);
        r.y = coord_t'(y);
        r.off = off;
        touch_q.push_back(r);
        if (op == OP_DISPLAY)
            gen_asleep = off;
    endtask

    // Random value in [lo, hi]; anywhere on the panel when the range is empty.
    function automatic int pick(int lo, int hi);
        if (lo > hi)
            return $urandom_range(0, 4095);
        return $urandom_range(hi, lo);
    endfunction

    // Register write: setup phase, then access phase; the write lands at the edge closing the access phase.
    task automatic reg_write(reg_idx_t idx, logic [DATA_W-1:0] val);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_ENABLE:     cfg_enable = val[0];
            REG_SLEEP_ONLY: cfg_sleep_only = val[0];
            REG_X_LO:       cfg_x_lo = coord_t'(val);
            REG_X_HI:       cfg_x_hi = coord_t'(val);
            REG_Y_LO:       cfg_y_lo = coord_t'(val);
            REG_Y_HI:       cfg_y_hi = coord_t'(val);
            default: ;
        endcase
    endtask

    task automatic program_detector(bit en, bit so, int xl, int xh, int yl, int yh);
        reg_write(REG_ENABLE, DATA_W'(en));
        reg_write(REG_SLEEP_ONLY, DATA_W'(so));
        reg_write(REG_X_LO, xl);
        reg_write(REG_X_HI, xh);
        reg_write(REG_Y_LO, yl);
        reg_write(REG_Y_HI, yh);
    endtask

    // Wait until every request is taken and every result is back, then let the
    // two-stage pipeline settle before touching the registers.
    task automatic wait_drained();
        do
            @(negedge clk);
        while (touch_q.size() != 0 || in_valid || expected_keys.size() != 0);
        repeat (4) @(negedge clk);
    endtask

    // Queue mostly well-formed swipes in the direction the screen state calls
    // for, ended by a release or a disconnect, with some stray points, rejects and pure noise.
    task automatic queue_phase(int quota);
        int added;
        int steps;
        int span;
        int lo_x;
        int hi_x;
        int sx;
        int ex;
        int x;
        int y;
        int y_line;
        int k;
        int tail;
        bit clean;
        added = 0;
        while (added < quota) begin
            if ($urandom_range(0, 4) == 0) begin
                push_req(3'($urandom_range(0, 7)), $urandom, $urandom,
                         1'($urandom_range(0, 1)));
                added++;
            end
            else begin
                if ($urandom_range(0, 5) == 0) begin
                    push_req(OP_DISPLAY, $urandom, $urandom, 1'($urandom_range(0, 1)));
                    added++;
                end
                lo_x = int'(cfg_x_lo);
                hi_x = int'(cfg_x_hi);
                if (hi_x < lo_x) begin
                    // inverted window: aim across the whole panel, all of it misses
                    lo_x = 0;
                    hi_x = 4095;
                end
                if (cfg_y_hi >= cfg_y_lo)
                    y_line = int'(cfg_y_hi)
                           - (int'(cfg_y_hi) - int'(cfg_y_lo)) * PCT_BAND / PCT_FULL;
                else
                    y_line = 4095;
                span = hi_x - lo_x;
                steps = $urandom_range(2, 7);
                if (gen_asleep) begin
                    sx = lo_x + $urandom_range(0, span / 4);
                    ex = sx + $urandom_range(span / 2, span);
                    if (ex > hi_x)
                        ex = hi_x;
                end
                else begin
                    sx = hi_x - $urandom_range(0, span / 4);
                    ex = sx - $urandom_range(span / 2, span);
                    if (ex < lo_x)
                        ex = lo_x;
                end
                clean = ($urandom_range(0, 7) != 0);
                for (k = 0; k < steps; k++) begin
                    x = sx + (ex - sx) * k / (steps - 1);
                    if (!clean && k == steps / 2)
                        x = $urandom_range(0, 4095);
                    if (!gen_asleep && y_line < cfg_y_hi)
                        y = pick(y_line + 1, int'(cfg_y_hi));
                    else
                        y = pick(int'(cfg_y_lo), int'(cfg_y_hi));
                    push_req(OP_POSITION, x, y, 1'($urandom_range(0, 1)));
                end
                added += steps;
                tail = $urandom_range(0, 9);
                if (tail == 9) begin
                    push_req(OP_REJECT, $urandom, $urandom, 1'($urandom_range(0, 1)));
                    added++;
                end
                if (tail == 8)
                    push_req(OP_DISCONNECT, $urandom, $urandom, 1'($urandom_range(0, 1)));
                else
                    push_req(OP_RELEASE, $urandom, $urandom, 1'($urandom_range(0, 1)));
                added++;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    int ph;
    int a;
    int b;

    initial begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part under reset settings: full window, threshold 2457,
        // bottom line at 3563.
        push_req(OP_DISPLAY, 0, 0, 1'b1);           // suspend the screen
        push_req(OP_POSITION, 0, 0, 1'b0);          // latch start at the left edge
        push_req(OP_POSITION, 2457, 4095, 1'b0);    // wake exactly at threshold
        push_req(OP_POSITION, 4095, 100, 1'b0);     // one-shot: no second press
        push_req(OP_RELEASE, 4095, 4095, 1'b1);
        push_req(OP_POSITION, 4095, 4095, 1'b1);    // start at the right edge
        push_req(OP_POSITION, 0, 0, 1'b0);          // wrong way, progress stays 0
        push_req(OP_REJECT, 0, 0, 1'b0);            // reject blocks the touch
        push_req(OP_POSITION, 4095, 2048, 1'b0);    // ignored while blocked
        push_req(OP_RELEASE, 0, 0, 1'b0);
        push_req(3'd5, 4095, 0, 1'b1);              // unused codes
        push_req(3'd6, 0, 4095, 1'b0);
        push_req(3'd7, 2730, 1365, 1'b1);
        push_req(OP_DISPLAY, 0, 0, 1'b0);           // wake the screen
        push_req(OP_POSITION, 4095, 4095, 1'b0);
        push_req(OP_POSITION, 1000, 3564, 1'b0);    // sleep swipe just below the line
        push_req(OP_RELEASE, 0, 0, 1'b0);
        push_req(OP_POSITION, 4095, 3563, 1'b0);    // on the line: invalid, blocked
        push_req(OP_POSITION, 0, 4095, 1'b0);       // still blocked
        push_req(OP_DISCONNECT, 0, 0, 1'b0);        // disconnect unblocks
        push_req(OP_POSITION, 3000, 4000, 1'b0);
        push_req(OP_POSITION, 543, 4000, 1'b0);     // leftward exactly at threshold
        push_req(OP_DISCONNECT, 4095, 4095, 1'b1);
        wait_drained();

        // Random phases, each under its own settings.
        for (ph = 0; ph < 8; ph++) begin
            a = $urandom_range(0, 4095);
            b = $urandom_range(0, 4095);
            case (ph)
                0: program_detector(1'b1, 1'b0, (a < b) ? a : b, (a < b) ? b : a, 0, 4095);
                1: program_detector(1'b1, 1'b1, 0, 4095, 0, 4095);   // sleep only
                2: program_detector(1'b0, 1'b0, 0, 4095, (a < b) ? a : b, (a < b) ? b : a);
                3: program_detector(1'b1, 1'b0, a, a, 0, 4095);       // one column, no distance
                4: program_detector(1'b1, 1'b0, 3000, 1000, 0, 4095); // inverted window
                5: program_detector(1'b1, 1'b0, 0, 4095, 4095, 4095); // no room below the line
                6: program_detector(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                    a, b, $urandom_range(0, 4095), $urandom_range(0, 4095));
                default: program_detector(1'b1, 1'b0, 0, 4095, 0, 4095);
            endcase
            @(negedge clk);
            queue_phase(104);
            wait_drained();
        end

        repeat (10) @(posedge clk);
        if (expected_keys.size() != 0) begin
            $display("%0t: %0d power key results never arrived", $time, expected_keys.size());
            mismatches++;
        end
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Drop out if the detector stops answering.
    initial begin
        #2000000;
        $display("%0t: timed out waiting for the detector", $time);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/sgwd_pkg.sv
rtl/swipe_gesture_wake_detector_core.sv
rtl/sgwd_checker.sv
test/tb.sv
